// ----- src/trailing_moving_average_macros.svh -----
// Assertion helpers for the moving average block.
// All checks are sampled on the rising edge of clk and are off during reset.
`ifndef TRAILING_MOVING_AVERAGE_MACROS_SVH
`define TRAILING_MOVING_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tma_pkg.sv -----
`default_nettype none

package tma_pkg;

	// Fixed field widths of the stream.
	localparam int SAMPLE_BITS = 16;
	localparam int LOOK_BACK_BITS = 4;
	localparam int LOOK_BACK_MAX = (1 << LOOK_BACK_BITS) - 1;
	localparam logic [LOOK_BACK_BITS-1:0] LOOK_BACK_RESET = LOOK_BACK_BITS'(1);

	// Default depth of the history memory.
	localparam int MAX_WINDOW_DEF = 16;

	// A window holds at most LOOK_BACK_MAX+1 samples, so the sum needs this many bits.
	localparam int SUM_BITS = SAMPLE_BITS + LOOK_BACK_BITS;
	// The divisor look_back+1 needs one bit more than look_back.
	localparam int DIV_BITS = LOOK_BACK_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

	// Input beat.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic last_in;
	} in_beat_t;

	// Output beat.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic last_out;
	} out_beat_t;

	// Classified sample handed from the front to the back.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic last_in;
		logic do_avg;
		logic [LOOK_BACK_BITS-1:0] k;
	} job_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_SUM,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

// ----- src/tma_front.sv -----
`default_nettype none

module tma_front #(
	parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire tma_pkg::in_beat_t                     in_beat,
	input  wire logic [tma_pkg::LOOK_BACK_BITS-1:0]    look_back,
	output logic                                       job_valid,
	input  wire logic                                  job_ready,
	output tma_pkg::job_t                              job,
	output logic [$clog2(MAX_WINDOW+1)-1:0]            position
);

	localparam int POS_BITS = $clog2(MAX_WINDOW + 1);
	localparam int K_MAX_I = (MAX_WINDOW - 1 < tma_pkg::LOOK_BACK_MAX) ?
		MAX_WINDOW - 1 : tma_pkg::LOOK_BACK_MAX;
	localparam logic [tma_pkg::LOOK_BACK_BITS-1:0] K_MAX =
		tma_pkg::LOOK_BACK_BITS'(K_MAX_I);

	logic [POS_BITS-1:0] pos_q;
	logic [tma_pkg::LOOK_BACK_BITS-1:0] k;
	logic accept;

	// Clamp the look-back to what the history can hold.
	assign k = (look_back > K_MAX) ? K_MAX : look_back;

	// A beat is taken whenever the queue has room.
	assign in_ready = job_ready;
	assign job_valid = in_valid;
	assign accept = in_valid && job_ready;

	// Classify: a full window exists once the run is at least k samples old.
	always_comb begin
		job.sample = in_beat.sample;
		job.last_in = in_beat.last_in;
		job.k = k;
		job.do_avg = (32'(pos_q) >= 32'(k));
	end

	// Position within the run, saturating, cleared after the last sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (in_beat.last_in) begin
				pos_q <= '0;
			end else if (32'(pos_q) < MAX_WINDOW) begin
				pos_q <= pos_q + POS_BITS'(1);
			end
		end
	end

	assign position = pos_q;

endmodule

`default_nettype wire

// ----- src/tma_queue.sv -----
`default_nettype none

module tma_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire tma_pkg::job_t  push_job,
	output logic                pop_valid,
	input  wire logic           pop,
	output tma_pkg::job_t       pop_job
);

	tma_pkg::job_t ent_q [2];
	logic head_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job = ent_q[head_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	// Entry storage: the tail sits one past the head when one entry is held.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[head_q ^ count_q[0]] <= push_job;
		end
	end

	// Head pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_pop) begin
				head_q <= ~head_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tma_back.sv -----
`default_nettype none

module tma_back #(
	parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_pop,
	input  wire tma_pkg::job_t      job,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tma_pkg::out_beat_t      out_beat
);

	localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SB = tma_pkg::SAMPLE_BITS;
	localparam int SUMB = tma_pkg::SUM_BITS;
	localparam int DB = tma_pkg::DIV_BITS;
	localparam int LB = tma_pkg::LOOK_BACK_BITS;
	localparam int CB = tma_pkg::DIV_CNT_BITS;
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(MAX_WINDOW - 1);

	tma_pkg::back_state_t state_q, state_d;

	logic signed [SB-1:0] hist_mem [MAX_WINDOW];
	logic signed [SB-1:0] rdata_q;

	logic [PTR_BITS-1:0] wp_q;
	logic [PTR_BITS-1:0] wp_next;
	logic [PTR_BITS-1:0] wp_prev;
	logic [PTR_BITS-1:0] addr_q;
	logic [PTR_BITS-1:0] addr_dec;
	logic [LB-1:0] left_q;
	logic pend_q;
	logic signed [SUMB-1:0] sum_q;
	logic signed [SB-1:0] sample_q;
	logic last_q;
	logic pass_q;
	logic [LB-1:0] k_q;
	logic neg_q;
	logic [SUMB-1:0] quo_q;
	logic [DB-1:0] rem_q;
	logic [CB-1:0] cnt_q;
	logic out_valid_q;
	tma_pkg::out_beat_t out_beat_q;

	logic load_out;
	logic sum_done;
	logic [DB-1:0] divisor;
	logic [DB-1:0] rem_sh;
	logic rem_ge;
	logic [SUMB-1:0] sum_mag;
	logic [SUMB-1:0] quo_signed;

	// Circular pointer arithmetic; the depth need not be a power of two.
	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_BITS'(1);
	assign wp_prev = (wp_q == '0) ? PTR_LAST : wp_q - PTR_BITS'(1);
	assign addr_dec = (addr_q == '0) ? PTR_LAST : addr_q - PTR_BITS'(1);

	// Window accumulation is over once every read is issued and drained.
	assign sum_done = (left_q == '0) && !pend_q;

	// One restoring division step per cycle on the magnitude.
	assign divisor = DB'(k_q) + DB'(1);
	assign rem_sh = {rem_q[DB-2:0], quo_q[SUMB-1]};
	assign rem_ge = (rem_sh >= divisor);
	assign sum_mag = sum_q[SUMB-1] ? SUMB'(-sum_q) : SUMB'(sum_q);
	assign quo_signed = neg_q ? (~quo_q + SUMB'(1)) : quo_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tma_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake strobes.
	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			tma_pkg::B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (job.do_avg && (job.k != '0)) begin
						state_d = tma_pkg::B_SUM;
					end else begin
						state_d = tma_pkg::B_DONE;
					end
				end
			end
			tma_pkg::B_SUM: begin
				if (sum_done) begin
					state_d = tma_pkg::B_DIV;
				end
			end
			tma_pkg::B_DIV: begin
				if (cnt_q == '0) begin
					state_d = tma_pkg::B_DONE;
				end
			end
			tma_pkg::B_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = tma_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = tma_pkg::B_IDLE;
			end
		endcase
	end

	// History memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			hist_mem[wp_q] <= job.sample;
		end
		rdata_q <= hist_mem[addr_q];
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			left_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (job_pop) begin
				wp_q <= wp_next;
				left_q <= job.k;
				pend_q <= 1'b0;
			end else if (state_q == tma_pkg::B_SUM) begin
				pend_q <= (left_q != '0);
				if (left_q != '0) begin
					left_q <= left_q - LB'(1);
				end
			end
		end
	end

	// Sample, window sum and divider registers.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			sample_q <= job.sample;
			last_q <= job.last_in;
			k_q <= job.k;
			pass_q <= !(job.do_avg && (job.k != '0));
			sum_q <= SUMB'(job.sample);
			addr_q <= wp_prev;
		end else if (state_q == tma_pkg::B_SUM) begin
			if (left_q != '0) begin
				addr_q <= addr_dec;
			end
			if (pend_q) begin
				sum_q <= sum_q + SUMB'(rdata_q);
			end
			if (sum_done) begin
				neg_q <= sum_q[SUMB-1];
				quo_q <= sum_mag;
				rem_q <= '0;
				cnt_q <= CB'(SUMB - 1);
			end
		end else if (state_q == tma_pkg::B_DIV) begin
			rem_q <= rem_ge ? (rem_sh - divisor) : rem_sh;
			quo_q <= {quo_q[SUMB-2:0], rem_ge};
			cnt_q <= cnt_q - CB'(1);
		end
	end

	// Output register: holds a finished beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_beat_q.average <= pass_q ? sample_q : SB'(quo_signed);
			out_beat_q.last_out <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat = out_beat_q;

endmodule

`default_nettype wire

// ----- src/trailing_moving_average.sv -----
// Trailing moving average over a stream of signed Q8.8 samples.
// Input channel in_valid/in_ready/in_beat carries one sample and a last flag
// per beat; output channel out_valid/out_ready/out_beat returns one result per
// sample, in order, with the last flag copied.
// Within a run, a sample at position below look_back is passed through; from
// then on the result is the mean of it and the look_back samples before it,
// truncated toward zero. look_back is written through cfg_valid/cfg_data,
// which is always ready; reset loads look_back with 1.
// A front stage tracks the run position and classifies each sample into a
// two-entry queue. The back end reads the history memory one entry a cycle
// and divides with a one-bit-per-cycle restoring divider.
// Sequence: a passed-through sample goes from B_IDLE to B_DONE; an averaged
// one also runs B_SUM (k memory reads, then draining the last read and
// closing the sum) and B_DIV (20 divide steps) in between. With an idle
// back end the queued beat is taken in the cycle after acceptance. The back
// end starts a new sample only once the last result is in the output register.
// Reset clears the run position, the history pointer, the queue and the
// output register. When the receiver stalls, the result waits in the output
// register, the back end finishes the next item and holds, and in_ready
// drops once the queue is full.
`default_nettype none

`include "trailing_moving_average_macros.svh"

module trailing_moving_average #(
	parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire tma_pkg::in_beat_t                   in_beat,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output tma_pkg::out_beat_t                       out_beat,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tma_pkg::LOOK_BACK_BITS-1:0]  cfg_data
);

	localparam int POS_BITS = $clog2(MAX_WINDOW + 1);

	logic [tma_pkg::LOOK_BACK_BITS-1:0] look_back_q;
	logic push_valid;
	logic push_ready;
	tma_pkg::job_t push_job;
	logic job_valid;
	logic job_pop;
	tma_pkg::job_t job;
	logic [POS_BITS-1:0] front_pos;

	// Look-back register, always ready for a write beat.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_back_q <= tma_pkg::LOOK_BACK_RESET;
		end else if (cfg_valid) begin
			look_back_q <= cfg_data;
		end
	end

	// Front: run position and classification.
	tma_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_beat(in_beat),
		.look_back(look_back_q),
		.job_valid(push_valid),
		.job_ready(push_ready),
		.job(push_job),
		.position(front_pos)
	);

	// Queue between front and back.
	tma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.pop_valid(job_valid),
		.pop(job_pop),
		.pop_job(job)
	);

	// Back: history, window sum, divider and output register.
	tma_back #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_pop(job_pop),
		.job(job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat)
	);

	// A last sample restarts the run.
	`TMA_ASSERT_NEXT(a_last_clears_pos, in_valid && in_ready && in_beat.last_in, front_pos == '0, "position not cleared after last sample")
	// The back end only takes a job that the queue holds.
	`TMA_ASSERT_NOW(a_pop_nonempty, job_pop, job_valid, "job popped from empty queue")
	// The run position saturates at the history depth.
	`TMA_ASSERT_NOW(a_pos_bound, 1'b1, 32'(front_pos) <= MAX_WINDOW, "run position out of range")

endmodule

`default_nettype wire
